// ----- sv/mma_pkg.sv -----
// mma_pkg: widths, item record and queue status shared by the moving-average block
// used by the channel interfaces, front, queue, back end and top level; no dependencies

package mma_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int CHAN_W      = 2;
   // 64 * 4095 stays below 2**18
   localparam int SUM_W       = 18;
   // reciprocal multiplier width, enough for any window length up to 64
   localparam int MUL_W       = SUM_W + 2;
   localparam int PROD_W      = SUM_W + MUL_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // one classified item as it travels from front to back
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [CHAN_W-1:0]   channel;
      logic                in_range;
   } item_type;

   // queue status seen by front and back
   typedef struct packed {
      logic has_item;
      logic has_room;
   } queue_status_type;

endpackage

// ----- sv/mma_if.sv -----
// mma_req_if / mma_rsp_if: valid-ready channels for samples and averages
// depends on mma_pkg for field widths

interface mma_req_if;
   logic                         valid;
   logic                         ready;
   logic [mma_pkg::SAMPLE_W-1:0] sample;
   logic [mma_pkg::CHAN_W-1:0]   channel;

   modport source (output valid, output sample, output channel, input ready);
   modport sink (input valid, input sample, input channel, output ready);
endinterface

interface mma_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mma_pkg::SAMPLE_W-1:0] average;
   logic [mma_pkg::CHAN_W-1:0]   channel_out;

   modport source (output valid, output average, output channel_out, input ready);
   modport sink (input valid, input average, input channel_out, output ready);
endinterface

// ----- sv/mma_front.sv -----
// mma_front: intake register that takes request transfers and tags each with its range check
// depends on mma_pkg and mma_req_if; feeds mma_queue

module mma_front #(
   parameter int CHANNELS = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   mma_req_if.sink                   req_bus,
   input  mma_pkg::queue_status_type queue_status,
   output logic                      push,
   output mma_pkg::item_type         item
);

   logic              valid_ff, valid_in;
   mma_pkg::item_type item_ff, item_in;
   logic              take;

   // room when empty or when the held item moves into the queue this cycle
   assign push          = valid_ff && queue_status.has_room;
   assign req_bus.ready = !valid_ff || queue_status.has_room;
   assign take          = req_bus.valid && req_bus.ready;

   // classify the incoming transfer
   always_comb begin
      item_in.sample   = req_bus.sample;
      item_in.channel  = req_bus.channel;
      item_in.in_range = int'(req_bus.channel) < CHANNELS;
      valid_in         = take || (valid_ff && !push);
   end

   // intake register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item = item_ff;

endmodule

// ----- sv/mma_queue.sv -----
// mma_queue: small first-in first-out queue of classified items between front and back
// depends on mma_pkg

module mma_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mma_pkg::item_type         push_item,
   input  logic                      pop,
   output mma_pkg::item_type         head_item,
   output mma_pkg::queue_status_type status
);

   mma_pkg::item_type               entry_ff [mma_pkg::QUEUE_DEPTH];
   logic [mma_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [mma_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [mma_pkg::QCOUNT_W-1:0]    count_ff, count_in;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item       = entry_ff[rd_ptr_ff];
   assign status.has_item = count_ff != '0;
   assign status.has_room = count_ff != mma_pkg::QCOUNT_W'(mma_pkg::QUEUE_DEPTH);

   // no transfer into a full queue, none out of an empty one
   assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff < mma_pkg::QCOUNT_W'(mma_pkg::QUEUE_DEPTH))
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue underflow");

endmodule

// ----- sv/mma_back.sv -----
// mma_back: window ring buffers, running sums, reciprocal divide and result register
// depends on mma_pkg and mma_rsp_if; drains mma_queue

module mma_back #(
   parameter int WINDOW_LENGTH = 8,
   parameter int CHANNELS      = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mma_pkg::queue_status_type queue_status,
   input  mma_pkg::item_type         head_item,
   output logic                      pop,
   mma_rsp_if.source                 rsp_bus
);

   localparam int DEPTH    = CHANNELS * WINDOW_LENGTH;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PTR_W    = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
   localparam int FILL_W   = $clog2(WINDOW_LENGTH + 1);
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   // exact truncating divide by multiply and shift for any dividend below 2**SUM_W
   localparam int SHIFT    = mma_pkg::SUM_W + $clog2(WINDOW_LENGTH);
   localparam longint RECIP = ((longint'(1) << SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
   localparam logic [mma_pkg::MUL_W-1:0] RECIP_C = mma_pkg::MUL_W'(RECIP);
   localparam logic [mma_pkg::SUM_W-1:0] SUM_MAX =
      mma_pkg::SUM_W'(WINDOW_LENGTH * ((1 << mma_pkg::SAMPLE_W) - 1));

   logic advance;

   // window ring buffers, one region of WINDOW_LENGTH entries per channel
   logic [mma_pkg::SAMPLE_W-1:0] window_mem [DEPTH];
   logic [PTR_W-1:0]             ptr_ff  [CHANNELS];
   logic [FILL_W-1:0]            fill_ff [CHANNELS];
   logic [CH_IDX_W-1:0]          head_idx;
   logic [PTR_W-1:0]             head_ptr;
   logic [FILL_W-1:0]            head_fill;
   logic [ADDR_W-1:0]            mem_addr;

   // stage 1: oldest sample read
   logic                         s1_valid_ff;
   mma_pkg::item_type            s1_item_ff;
   logic                         s1_empty_slot_ff;
   logic [mma_pkg::SAMPLE_W-1:0] s1_oldest_ff;
   logic [mma_pkg::SAMPLE_W-1:0] oldest;
   logic [CH_IDX_W-1:0]          s1_idx;

   // stage 2: running sum
   logic [mma_pkg::SUM_W-1:0]    sum_ff [CHANNELS];
   logic [mma_pkg::SUM_W-1:0]    sum_in;
   logic                         s2_valid_ff;
   logic [mma_pkg::CHAN_W-1:0]   s2_channel_ff;
   logic [mma_pkg::SUM_W-1:0]    s2_sum_ff;

   // stage 3: reciprocal product
   logic                         s3_valid_ff;
   logic [mma_pkg::CHAN_W-1:0]   s3_channel_ff;
   logic [mma_pkg::PROD_W-1:0]   s3_prod_ff, prod_in;

   // result register
   logic                         rsp_valid_ff;
   logic [mma_pkg::SAMPLE_W-1:0] rsp_average_ff;
   logic [mma_pkg::CHAN_W-1:0]   rsp_channel_ff;

   // whole back end moves unless a result waits on a stalled sink
   assign advance = !rsp_valid_ff || rsp_bus.ready;
   assign pop     = advance && queue_status.has_item;

   // address of the slot about to be overwritten, which holds the oldest sample
   always_comb begin
      head_idx  = CH_IDX_W'(head_item.channel);
      head_ptr  = '0;
      head_fill = '0;
      mem_addr  = '0;
      if (head_item.in_range) begin
         head_ptr  = ptr_ff[head_idx];
         head_fill = fill_ff[head_idx];
         mem_addr  = ADDR_W'(int'(head_idx) * WINDOW_LENGTH + int'(head_ptr));
      end
   end

   // per-channel ring pointer and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            ptr_ff[c]  <= '0;
            fill_ff[c] <= '0;
         end
      end else if (pop && head_item.in_range) begin
         if (head_ptr == PTR_W'(WINDOW_LENGTH - 1)) begin
            ptr_ff[head_idx] <= '0;
         end else begin
            ptr_ff[head_idx] <= head_ptr + 1'b1;
         end
         if (head_fill != FILL_W'(WINDOW_LENGTH)) begin
            fill_ff[head_idx] <= head_fill + 1'b1;
         end
      end
   end

   // window memory: oldest read and newest written at the same slot
   always_ff @(posedge clock) begin
      if (pop && head_item.in_range) begin
         window_mem[mem_addr] <= head_item.sample;
      end
      if (advance) begin
         s1_oldest_ff <= window_mem[mem_addr];
      end
   end

   // stage 1 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= pop;
      end
      if (advance) begin
         s1_item_ff       <= head_item;
         s1_empty_slot_ff <= head_fill != FILL_W'(WINDOW_LENGTH);
      end
   end

   // slot never written reads as zero
   assign oldest = s1_empty_slot_ff ? '0 : s1_oldest_ff;
   assign s1_idx = CH_IDX_W'(s1_item_ff.channel);

   always_comb begin
      sum_in = '0;
      if (s1_item_ff.in_range) begin
         sum_in = sum_ff[s1_idx] + mma_pkg::SUM_W'(s1_item_ff.sample)
                  - mma_pkg::SUM_W'(oldest);
      end
   end

   // stage 2: running sums and sum register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            sum_ff[c] <= '0;
         end
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         if (s1_valid_ff && s1_item_ff.in_range) begin
            sum_ff[s1_idx] <= sum_in;
         end
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_channel_ff <= s1_item_ff.channel;
         s2_sum_ff     <= sum_in;
      end
   end

   // stage 3: multiply by the reciprocal of the window length
   assign prod_in = s2_sum_ff * RECIP_C;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_channel_ff <= s2_channel_ff;
         s3_prod_ff    <= prod_in;
      end
   end

   // result register, holds while the sink stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         rsp_average_ff <= s3_prod_ff[SHIFT +: mma_pkg::SAMPLE_W];
         rsp_channel_ff <= s3_channel_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.average     = rsp_average_ff;
   assign rsp_bus.channel_out = rsp_channel_ff;

   // running sums never exceed a full window of maximum samples
   for (genvar c = 0; c < CHANNELS; c++) begin : g_check
      assert property (@(posedge clock) disable iff (reset)
         sum_ff[c] <= SUM_MAX)
         else $error("running sum out of range");
      assert property (@(posedge clock) disable iff (reset)
         fill_ff[c] <= FILL_W'(WINDOW_LENGTH))
         else $error("fill count past window length");
   end

   // an item in stage 1 moves into stage 2 on the next advance
   assert property (@(posedge clock) disable iff (reset)
      (advance && s1_valid_ff) |=> s2_valid_ff)
      else $error("item lost between stage 1 and stage 2");

endmodule

// ----- sv/multichannel_moving_average.sv -----
// multichannel_moving_average: top level of the per-channel boxcar averaging filter
// depends on mma_pkg, mma_req_if, mma_rsp_if, mma_front, mma_queue and mma_back
//
//   port      dir   role      payload
//   req_bus   in    sink      sample[11:0], channel[1:0]
//   rsp_bus   out   source    average[11:0], channel_out[1:0]
//
// one item per cycle sustained while the result side does not stall; each item passes
// in order through the intake register, queue, window memory read, running sum,
// reciprocal multiply and result register before its result is offered on rsp_bus
// the rate is set by the single window memory port, which reads the oldest sample
// and writes the new one of the same item in the same cycle
// reset clears the per-channel fill counts, which stand in for clearing window memory
// rsp_bus.ready low with a result waiting freezes the back end; the four-entry queue and
// intake register keep req_bus.ready high for up to five more transfers

module multichannel_moving_average #(
   parameter int WINDOW_LENGTH = 8,
   parameter int CHANNELS      = 4
) (
   input  logic       clock,
   input  logic       reset,
   mma_req_if.sink    req_bus,
   mma_rsp_if.source  rsp_bus
);

   mma_pkg::queue_status_type queue_status;
   mma_pkg::item_type         front_item;
   mma_pkg::item_type         head_item;
   logic                      push;
   logic                      pop;

   // front: takes transfers and checks the channel
   mma_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .queue_status (queue_status),
      .push         (push),
      .item         (front_item)
   );

   // queue between front and back end
   mma_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (queue_status)
   );

   // back end: window update, running sum and divide
   mma_back #(
      .WINDOW_LENGTH (WINDOW_LENGTH),
      .CHANNELS      (CHANNELS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head_item    (head_item),
      .pop          (pop),
      .rsp_bus      (rsp_bus)
   );

endmodule

// ----- dv/mma_checker.sv -----
`timescale 1ns / 1ps
// mma_checker: tracks each channel's window and running sum from observed sample
// transfers, predicts every average and compares it with the result transfers
// depends on mma_pkg and the mma_req_if / mma_rsp_if interfaces

module mma_checker #(
   parameter int WINDOW_LENGTH = 8,
   parameter int CHANNELS      = 4
) (
   input  logic clock,
   input  logic reset,
   mma_req_if   req_bus,
   mma_rsp_if   rsp_bus,
   output int   fail_count,
   output int   averages_checked,
   output int   averages_pending
);

   import mma_pkg::*;

   // one predicted average as it should appear on the result channel
   typedef struct packed {
      logic [SAMPLE_W-1:0] average;
      logic [CHAN_W-1:0]   channel;
   } average_rec_type;

   logic [SAMPLE_W-1:0] window_hist [CHANNELS][WINDOW_LENGTH];
   logic [SUM_W-1:0]    chan_sum [CHANNELS];
   average_rec_type     averages_due [$];
   int                  mismatches = 0;
   int                  checked    = 0;

   // shift a sample into its channel's window and return the new truncated mean
   function automatic average_rec_type advance_window(input logic [SAMPLE_W-1:0] sample,
                                                      input logic [CHAN_W-1:0]   channel);
      average_rec_type     rec;
      logic [SAMPLE_W-1:0] oldest;
      int                  i;
      rec.channel = channel;
      rec.average = '0;
      // a channel beyond the configured count leaves all state alone
      if (int'(channel) < CHANNELS) begin
         oldest = window_hist[channel][WINDOW_LENGTH-1];
         for (i = WINDOW_LENGTH - 1; i > 0; i--) begin
            window_hist[channel][i] = window_hist[channel][i-1];
         end
         window_hist[channel][0] = sample;
         chan_sum[channel] = chan_sum[channel] + SUM_W'(sample) - SUM_W'(oldest);
         rec.average = SAMPLE_W'(chan_sum[channel] / WINDOW_LENGTH);
      end
      return rec;
   endfunction

   always @(posedge clock) begin
      average_rec_type got;
      average_rec_type want;
      if (reset) begin
         // windows and sums start from zero
         foreach (window_hist[c, k]) window_hist[c][k] = '0;
         foreach (chan_sum[c]) chan_sum[c] = '0;
         averages_due.delete();
      end else begin
         // result transfer: compare against the oldest prediction
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.average = rsp_bus.average;
            got.channel = rsp_bus.channel_out;
            if (averages_due.size() == 0) begin
               $display("%0t: unexpected average, expected none, actual avg=%0d ch=%0d",
                        $time, got.average, got.channel);
               mismatches++;
            end else begin
               want = averages_due.pop_front();
               checked++;
               if (got.average !== want.average) begin
                  $display("%0t: average mismatch on ch %0d, expected %0d, actual %0d",
                           $time, want.channel, want.average, got.average);
                  mismatches++;
               end
               if (got.channel !== want.channel) begin
                  $display("%0t: channel_out mismatch, expected %0d, actual %0d",
                           $time, want.channel, got.channel);
                  mismatches++;
               end
            end
         end
         // sample transfer: predict its average
         if (req_bus.valid && req_bus.ready) begin
            averages_due.push_back(advance_window(req_bus.sample, req_bus.channel));
         end
      end
      fail_count       <= mismatches;
      averages_checked <= checked;
      averages_pending <= averages_due.size();
   end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// tb: stimulus and verdict for multichannel_moving_average; directed extremes, then
// random bursts per channel with random stalls on both sides; checking is in mma_checker
// depends on mma_pkg, mma_req_if, mma_rsp_if, mma_checker and the block itself

module tb;

   import mma_pkg::*;

   localparam int WINDOW_LENGTH = 8;
   localparam int CHANNELS      = 4;
   localparam int RANDOM_ITEMS  = 400;
   localparam int IDLE_PERCENT  = 26;
   localparam int DRAIN_CYCLES  = 12;
   localparam int CYCLE_LIMIT   = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   calm  = 1'b0;
   int   cycle_count = 0;
   int   samples_sent = 0;
   int   fail_count;
   int   averages_checked;
   int   averages_pending;

   mma_req_if req_bus ();
   mma_rsp_if rsp_bus ();

   multichannel_moving_average #(
      .WINDOW_LENGTH(WINDOW_LENGTH),
      .CHANNELS     (CHANNELS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   mma_checker #(
      .WINDOW_LENGTH(WINDOW_LENGTH),
      .CHANNELS     (CHANNELS)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .fail_count      (fail_count),
      .averages_checked(averages_checked),
      .averages_pending(averages_pending)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d averages outstanding", $time, averages_pending);
         $display("** multichannel_moving_average: FAILED **");
         $finish;
      end
   end

   // result side back-pressure, none during the calm stretch
   always @(posedge clock) begin
      rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // mostly uniform samples, with full scale, zero and small values favored
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return SAMPLE_W'($urandom_range(15));
         default: return SAMPLE_W'($urandom_range(4095));
      endcase
   endfunction

   // one sample transfer, with random idle cycles ahead of it outside the calm stretch
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample,
                              input logic [CHAN_W-1:0]   channel);
      if (!calm) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid   <= 1'b1;
      req_bus.sample  <= sample;
      req_bus.channel <= channel;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      samples_sent++;
   endtask

   initial begin
      int               k;
      int               run_len;
      int               random_sent;
      logic [CHAN_W-1:0] ch;
      req_bus.valid   = 1'b0;
      req_bus.sample  = '0;
      req_bus.channel = '0;
      rsp_bus.ready   = 1'b0;
      random_sent     = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: fill channel 0 with full scale past a whole window, then drop to zero
      for (k = 0; k < WINDOW_LENGTH + 1; k++) send_sample('1, 2'd0);
      send_sample('0, 2'd0);
      // alternating bit patterns, small and large values on other channels at start-up
      send_sample(12'hAAA, 2'd1);
      send_sample(12'h555, 2'd2);
      send_sample(12'h001, 2'd3);
      send_sample(12'h800, 2'd3);
      send_sample(12'h7FF, 2'd1);
      send_sample('1, 2'd2);

      // random: bursts on one channel mixed with scattered channels
      while (random_sent < RANDOM_ITEMS) begin
         calm = (random_sent >= 150 && random_sent < 250);
         if ($urandom_range(99) < 40) begin
            ch      = CHAN_W'($urandom_range(3));
            run_len = $urandom_range(1, 12);
            for (k = 0; k < run_len; k++) begin
               send_sample(pick_sample(), ch);
               random_sent++;
            end
         end else begin
            send_sample(pick_sample(), CHAN_W'($urandom_range(3)));
            random_sent++;
         end
      end
      calm = 1'b0;
      req_bus.valid <= 1'b0;

      // drain outstanding averages, then allow for stray results
      @(posedge clock);
      while (averages_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d sample transfers across %0d channels, %0d averages checked",
               samples_sent, CHANNELS, averages_checked);
      $display("including full-scale windows, start-up zeros and stalls on both sides");
      if (fail_count == 0) begin
         $display("** multichannel_moving_average: PASSED **");
      end else begin
         $display("** multichannel_moving_average: FAILED **");
      end
      $finish;
   end

endmodule
